// ----- hw/rtl/iqd_pkg.sv -----
// ----------------------------------------------------------------------------
// IQ demodulator package
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package iqd_pkg;

    // Internal datapath: signed values with 24 fraction bits.
    localparam int DW   = 32;
    localparam int ZW   = 34;
    localparam int FRAC = 24;

    localparam logic signed [31:0] KGAIN = 32'sd652032874;

    localparam logic [2:0] REG_OUTPUT_MODE      = 3'd0;
    localparam logic [2:0] REG_NCO_STEP         = 3'd1;
    localparam logic [2:0] REG_START_PHASE      = 3'd2;
    localparam logic [2:0] REG_ORIGIN_OFFSETS   = 3'd3;
    localparam logic [2:0] REG_IQ_ROTATION      = 3'd4;
    localparam logic [2:0] REG_IMBALANCE_MATRIX = 3'd5;
    localparam logic [2:0] REG_OUTPUT_GAINS     = 3'd6;
    localparam logic [2:0] REG_OPTION_FLAGS     = 3'd7;

    localparam logic [1:0] MODE_IQ        = 2'd0;
    localparam logic [1:0] MODE_AMP_PHASE = 2'd1;
    localparam logic [1:0] MODE_AMP_FREQ  = 2'd2;

    typedef struct packed {
        logic                 vec;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    // Arctangent of 2^-idx, 2^32 per turn.
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/iqd_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// CORDIC cell
// One registered micro-rotation, in rotation or vectoring mode.
// ----------------------------------------------------------------------------
module iqd_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  iqd_pkg::cordic_t in_data,
    output logic            out_valid,
    output iqd_pkg::cordic_t out_data
);
    import iqd_pkg::*;

    logic                 cw;
    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;
    logic signed [ZW-1:0] t;
    logic                 valid_reg;
    cordic_t              data_reg;
    cordic_t              data_next;

    assign xs = in_data.x >>> SHIFT;
    assign ys = in_data.y >>> SHIFT;
    assign t  = ZW'(atan_entry(SHIFT));

    // Vectoring drives y toward zero; rotation drives z toward zero.
    assign cw = in_data.vec ? (in_data.y >= 0) : (in_data.z < 0);

    always_comb
    begin
        data_next.vec = in_data.vec;
        if (cw)
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + t;
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/iqd_cordic_chain.sv -----
// ----------------------------------------------------------------------------
// CORDIC chain
// A row of CORDIC cells, one micro-rotation per cell and clock.
// ----------------------------------------------------------------------------
module iqd_cordic_chain #(
    parameter int STAGES = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  iqd_pkg::cordic_t in_data,
    output logic            out_valid,
    output iqd_pkg::cordic_t out_data
);
    import iqd_pkg::*;

    logic    valid_s [0:STAGES];
    cordic_t data_s  [0:STAGES];

    assign valid_s[0] = in_valid;
    assign data_s[0]  = in_data;

    for (genvar g = 0; g < STAGES; g++)
    begin : g_cell
        iqd_cordic_cell #(
            .SHIFT(g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (valid_s[g]),
            .in_data  (data_s[g]),
            .out_valid(valid_s[g+1]),
            .out_data (data_s[g+1])
        );
    end

    assign out_valid = valid_s[STAGES];
    assign out_data  = data_s[STAGES];

endmodule

// ----- hw/rtl/iq_demodulator_am_pm_fm.sv -----
// ----------------------------------------------------------------------------
// IQ demodulator with I/Q, amplitude, unwrapped phase and frequency outputs
// NCO derotation, offsets, fixed rotation, imbalance correction, CORDIC
// magnitude and phase, phase unwrap and output scaling.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  input     in         in_valid, in_stall   i_sample, q_sample
//  output    out        out_valid, out_stall first_out, second_out
//  config    in         cfg_write            cfg_index, cfg_data
//
// Each item makes three passes through the single CORDIC chain.
// A new item is accepted as soon as the previous one has reached the output
// register, even while that result is still stalled.
// Reset clears the NCO, the unwrap history and this module's registers to defaults.
// ----------------------------------------------------------------------------
module iq_demodulator_am_pm_fm #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int CORDIC_STAGES = 16,
    parameter int PHASE_WIDTH   = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] q_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] first_out,
    output logic signed [SAMPLE_WIDTH-1:0] second_out,
    input  logic                           cfg_write,
    input  logic [2:0]                     cfg_index,
    input  logic [63:0]                    cfg_data
);
    import iqd_pkg::*;

    localparam int XSH      = FRAC - (SAMPLE_WIDTH - 1);
    localparam int IQ_SHIFT = 8 + FRAC - (SAMPLE_WIDTH - 1);
    localparam int PH_SHIFT = 24 - SAMPLE_WIDTH;
    localparam logic signed [47:0] IQ_RND = 48'sd1 <<< (IQ_SHIFT - 1);
    localparam logic signed [47:0] PH_RND =
        (PH_SHIFT == 0) ? 48'sd0 : (48'sd1 <<< ((PH_SHIFT == 0) ? 0 : PH_SHIFT - 1));
    localparam logic signed [47:0] OUT_MAX = (48'sd1 <<< (SAMPLE_WIDTH - 1)) - 48'sd1;
    localparam logic signed [47:0] OUT_MIN = -(48'sd1 <<< (SAMPLE_WIDTH - 1));

    typedef enum logic [3:0] {
        S_IDLE, S_W1, S_ROT2, S_W2, S_MATP, S_MATS,
        S_VEC, S_W3, S_UNW, S_SCALE, S_OUT
    } state_t;

    // Configuration registers.
    logic [1:0]  mode_reg;
    logic [31:0] step_reg;
    logic [15:0] start_reg;
    logic [31:0] offs_reg;
    logic [15:0] iqrot_reg;
    logic [63:0] matrix_reg;
    logic [31:0] gains_reg;
    logic [1:0]  flags_reg;

    state_t                  state_reg;
    logic [PHASE_WIDTH-1:0]  nco_reg;
    logic [PHASE_WIDTH-1:0]  nco_next;
    logic [PHASE_WIDTH-1:0]  step_w;
    logic [31:0]             nco_ang;
    logic [31:0]             ang1;
    logic signed [DW-1:0]    x_reg;
    logic signed [DW-1:0]    y_reg;
    logic signed [DW-1:0]    amp_reg;
    logic signed [15:0]      raw_reg;
    logic signed [15:0]      d_reg;
    logic signed [31:0]      prev_reg;
    logic                    have_prev_reg;
    logic                    zero_reg;
    logic signed [47:0]      p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [47:0]      sp1_reg, sp2_reg;
    logic                    sec_ph_reg;
    logic                    out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] first_reg, second_reg;

    logic signed [DW-1:0]    smp_x, smp_y, off_i, off_q;
    logic signed [15:0]      ga, gp;
    logic signed [15:0]      c0, c1, c2, c3;
    logic                    chain_in_valid, chain_out_valid;
    cordic_t                 chain_in, chain_out, vec_data;
    logic [31:0]             zr;
    logic signed [15:0]      d_calc;
    logic signed [32:0]      unw_sum;
    logic signed [31:0]      unw_sat;
    logic signed [48:0]      msum_x, msum_y;
    logic signed [DW-1:0]    mat_x, mat_y, y_m;

    // NCO accumulator and its 2^32-per-turn angle.
    assign nco_next = nco_reg + step_w;
    if (PHASE_WIDTH >= 32)
    begin : g_wide
        assign step_w  = PHASE_WIDTH'(step_reg) << (PHASE_WIDTH - 32);
        assign nco_ang = nco_next[PHASE_WIDTH-1 -: 32];
    end
    else
    begin : g_narrow
        assign step_w  = PHASE_WIDTH'(step_reg >> (32 - PHASE_WIDTH));
        assign nco_ang = 32'(nco_next) << (32 - PHASE_WIDTH);
    end
    assign ang1 = nco_ang - {start_reg, 16'h0000};

    assign smp_x = DW'(i_sample) <<< XSH;
    assign smp_y = DW'(q_sample) <<< XSH;
    assign off_i = DW'(signed'(offs_reg[31:16])) <<< (FRAC - 15);
    assign off_q = DW'(signed'(offs_reg[15:0])) <<< (FRAC - 15);
    assign ga    = signed'(gains_reg[31:16]);
    assign gp    = signed'(gains_reg[15:0]);
    assign c0    = signed'(matrix_reg[63:48]);
    assign c1    = signed'(matrix_reg[47:32]);
    assign c2    = signed'(matrix_reg[31:16]);
    assign c3    = signed'(matrix_reg[15:0]);

    // Beyond a quarter turn the vector is negated and the angle moved by a half turn.
    function automatic cordic_t rot_launch(input logic [31:0] ang,
                                           input logic signed [DW-1:0] a,
                                           input logic signed [DW-1:0] b);
        logic signed [31:0] zs;
        cordic_t            r;
        zs    = signed'(ang);
        r.vec = 1'b0;
        if (zs > 32'sh4000_0000 || zs < -32'sh4000_0000)
        begin
            r.x = -a;
            r.y = -b;
            r.z = ZW'(signed'(ang + 32'h8000_0000));
        end
        else
        begin
            r.x = a;
            r.y = b;
            r.z = ZW'(zs);
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] kmul(input logic signed [DW-1:0] a);
        logic signed [63:0] p;
        p = a * KGAIN;
        p = p + (64'sd1 <<< 29);
        return DW'(p >>> 30);
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
        input logic signed [47:0] p, input logic ph);
        logic signed [47:0] r;
        if (ph)
            r = (p + PH_RND) >>> PH_SHIFT;
        else
            r = (p + IQ_RND) >>> IQ_SHIFT;
        if (r > OUT_MAX)
            r = OUT_MAX;
        else if (r < OUT_MIN)
            r = OUT_MIN;
        return SAMPLE_WIDTH'(r);
    endfunction

    always_comb
    begin
        vec_data.vec = 1'b1;
        if (x_reg < 0)
        begin
            vec_data.x = -x_reg;
            vec_data.y = -y_reg;
            vec_data.z = ZW'(34'sd2147483648);
        end
        else
        begin
            vec_data.x = x_reg;
            vec_data.y = y_reg;
            vec_data.z = '0;
        end
    end

    always_comb
    begin
        chain_in_valid = 1'b0;
        chain_in       = rot_launch(ang1, smp_x, smp_y);
        case (state_reg)
            S_IDLE:
            begin
                chain_in_valid = in_valid;
            end
            S_ROT2:
            begin
                chain_in_valid = 1'b1;
                chain_in = rot_launch({iqrot_reg, 16'h0000}, x_reg + off_i, y_reg + off_q);
            end
            S_VEC:
            begin
                chain_in_valid = 1'b1;
                chain_in       = vec_data;
            end
            default:
            begin
                chain_in_valid = 1'b0;
            end
        endcase
    end

    iqd_cordic_chain #(
        .STAGES(CORDIC_STAGES)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_in_valid),
        .in_data  (chain_in),
        .out_valid(chain_out_valid),
        .out_data (chain_out)
    );

    // Matrix sums and the Q value taken with or without the matrix.
    assign msum_x = 49'(p0_reg) + 49'(p1_reg) + 49'sd8192;
    assign msum_y = 49'(p2_reg) + 49'(p3_reg) + 49'sd8192;
    assign mat_x  = DW'(msum_x >>> 14);
    assign mat_y  = DW'(msum_y >>> 14);
    assign y_m    = flags_reg[0] ? mat_y : y_reg;

    assign zr = chain_out.z[31:0] + 32'h0000_8000;

    // Phase unwrap: the wrapped step is added to the previous unwrapped phase.
    assign d_calc  = raw_reg - prev_reg[15:0];
    assign unw_sum = 33'(prev_reg) + 33'(d_calc);
    always_comb
    begin
        if (!have_prev_reg)
            unw_sat = 32'(raw_reg);
        else if (unw_sum > 33'sh0_7FFF_FFFF)
            unw_sat = 32'sh7FFF_FFFF;
        else if (unw_sum < -33'sh0_8000_0000)
            unw_sat = -32'sh8000_0000;
        else
            unw_sat = 32'(unw_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IQ;
            step_reg   <= '0;
            start_reg  <= '0;
            offs_reg   <= '0;
            iqrot_reg  <= '0;
            matrix_reg <= 64'h4000_0000_0000_4000;
            gains_reg  <= 32'h0100_0100;
            flags_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_OUTPUT_MODE:      mode_reg   <= cfg_data[1:0];
                REG_NCO_STEP:         step_reg   <= cfg_data[31:0];
                REG_START_PHASE:      start_reg  <= cfg_data[15:0];
                REG_ORIGIN_OFFSETS:   offs_reg   <= cfg_data[31:0];
                REG_IQ_ROTATION:      iqrot_reg  <= cfg_data[15:0];
                REG_IMBALANCE_MATRIX: matrix_reg <= cfg_data;
                REG_OUTPUT_GAINS:     gains_reg  <= cfg_data[31:0];
                REG_OPTION_FLAGS:     flags_reg  <= cfg_data[1:0];
                default:              mode_reg   <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nco_reg       <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            amp_reg       <= '0;
            raw_reg       <= '0;
            d_reg         <= '0;
            zero_reg      <= 1'b0;
            p0_reg        <= '0;
            p1_reg        <= '0;
            p2_reg        <= '0;
            p3_reg        <= '0;
            sp1_reg       <= '0;
            sp2_reg       <= '0;
            sec_ph_reg    <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
        end
        else
        begin
            // In S_OUT the output register is loaded below instead.
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        nco_reg   <= nco_next;
                        state_reg <= S_W1;
                    end
                end
                S_W1:
                begin
                    if (chain_out_valid)
                    begin
                        x_reg     <= kmul(chain_out.x);
                        y_reg     <= kmul(chain_out.y);
                        state_reg <= S_ROT2;
                    end
                end
                S_ROT2:
                begin
                    state_reg <= S_W2;
                end
                S_W2:
                begin
                    if (chain_out_valid)
                    begin
                        x_reg     <= kmul(chain_out.x);
                        y_reg     <= kmul(chain_out.y);
                        state_reg <= S_MATP;
                    end
                end
                S_MATP:
                begin
                    p0_reg    <= c0 * x_reg;
                    p1_reg    <= c1 * y_reg;
                    p2_reg    <= c2 * x_reg;
                    p3_reg    <= c3 * y_reg;
                    state_reg <= S_MATS;
                end
                S_MATS:
                begin
                    if (flags_reg[0])
                        x_reg <= mat_x;
                    y_reg     <= flags_reg[1] ? -y_m : y_m;
                    state_reg <= S_VEC;
                end
                S_VEC:
                begin
                    zero_reg  <= (x_reg == 0) && (y_reg == 0);
                    state_reg <= S_W3;
                end
                S_W3:
                begin
                    if (chain_out_valid)
                    begin
                        // A zero vector has zero amplitude and zero phase.
                        if (zero_reg)
                        begin
                            amp_reg <= '0;
                            raw_reg <= '0;
                        end
                        else
                        begin
                            amp_reg <= kmul(chain_out.x);
                            raw_reg <= signed'(zr[31:16]);
                        end
                        state_reg <= S_UNW;
                    end
                end
                S_UNW:
                begin
                    d_reg         <= have_prev_reg ? d_calc : 16'sd0;
                    prev_reg      <= unw_sat;
                    have_prev_reg <= 1'b1;
                    state_reg     <= S_SCALE;
                end
                S_SCALE:
                begin
                    case (mode_reg)
                        MODE_IQ:
                        begin
                            sp1_reg    <= x_reg * ga;
                            sp2_reg    <= y_reg * ga;
                            sec_ph_reg <= 1'b0;
                        end
                        MODE_AMP_PHASE:
                        begin
                            sp1_reg    <= amp_reg * ga;
                            sp2_reg    <= prev_reg * gp;
                            sec_ph_reg <= 1'b1;
                        end
                        MODE_AMP_FREQ:
                        begin
                            sp1_reg    <= amp_reg * ga;
                            sp2_reg    <= d_reg * gp;
                            sec_ph_reg <= 1'b1;
                        end
                        default:
                        begin
                            sp1_reg    <= '0;
                            sp2_reg    <= '0;
                            sec_ph_reg <= 1'b0;
                        end
                    endcase
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!(out_valid_reg && out_stall))
                    begin
                        first_reg     <= round_sat(sp1_reg, 1'b0);
                        second_reg    <= round_sat(sp2_reg, sec_ph_reg);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign first_out  = first_reg;
    assign second_out = second_reg;

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// IQ demodulator testbench
// Drives complex samples through the demodulator under several register
// settings, predicts every output pair with a bit-true model of the fixed
// point datapath and compares the pairs in order as they leave the block.
// ----------------------------------------------------------------------------
module tb;
    import iqd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 3 * 16 + 7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] i_sample = '0;
    logic signed [15:0] q_sample = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] first_out;
    logic signed [15:0] second_out;
    logic               cfg_write = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [63:0]        cfg_data = '0;

    iq_demodulator_am_pm_fm dut (.*);

    always #2 clk = ~clk;

    // Predictor copy of the registers and the phase history.
    logic [1:0]  mode_r;
    logic [31:0] step_r, offsets_r, gains_r;
    logic [15:0] start_r, rot_r;
    logic [63:0] matrix_r;
    logic [1:0]  flags_r;
    logic [31:0] nco_acc, last_phase;
    bit          seen_sample;

    typedef struct packed {
        logic [15:0] first;
        logic [15:0] second;
    } out_pair_t;

    out_pair_t pending_pairs[$];
    int        errors = 0;
    int        send_gap_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_cycles = 0;

    localparam logic [31:0] ATAN_TAB [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [15:0] saturate16(longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic void cordic_rotate(inout longint x, inout longint y,
                                          input logic [31:0] ang);
        longint z, a, b, na, nb;
        z = sx32(ang);
        a = x;
        b = y;
        if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
            a = -a;
            b = -b;
            z = sx32(ang + 32'h8000_0000);
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                na = a - floor_shift(b, i);
                nb = b + floor_shift(a, i);
                z -= ATAN_TAB[i];
            end
            else begin
                na = a + floor_shift(b, i);
                nb = b - floor_shift(a, i);
                z += ATAN_TAB[i];
            end
            a = na;
            b = nb;
        end
        x = round_shift(a * 652032874, 30);
        y = round_shift(b * 652032874, 30);
    endfunction

    function automatic longint cordic_magnitude(longint x, longint y,
                                                output longint ph);
        longint z, nx, ny;
        logic [31:0] zt;
        logic [15:0] p;
        z = 0;
        if (x == 0 && y == 0) begin
            ph = 0;
            return 0;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'sd1 <<< 31;
        end
        for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                z += ATAN_TAB[i];
            end
            else begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                z -= ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        zt = z[31:0];
        p = 16'((33'(zt) + 33'h8000) >> 16);
        ph = longint'(signed'(p));
        return round_shift(x * 652032874, 30);
    endfunction

    function automatic logic [15:0] apply_gain(longint v, logic [15:0] g, int s);
        return saturate16(round_shift(v * longint'(signed'(g)), s));
    endfunction

    function automatic out_pair_t demodulate(logic [15:0] isamp, logic [15:0] qsamp);
        longint x, y, amp, raw, prv, d, unwr, nx, ny;
        logic [31:0] ang;
        logic [15:0] dw;
        out_pair_t r;
        nco_acc = nco_acc + step_r;
        ang = nco_acc - {start_r, 16'h0};
        x = longint'(signed'(isamp)) * 512;
        y = longint'(signed'(qsamp)) * 512;
        cordic_rotate(x, y, ang);
        x += longint'(signed'(offsets_r[31:16])) * 512;
        y += longint'(signed'(offsets_r[15:0])) * 512;
        cordic_rotate(x, y, {rot_r, 16'h0});
        if (flags_r[0]) begin
            nx = round_shift(longint'(signed'(matrix_r[63:48])) * x
                             + longint'(signed'(matrix_r[47:32])) * y, 14);
            ny = round_shift(longint'(signed'(matrix_r[31:16])) * x
                             + longint'(signed'(matrix_r[15:0])) * y, 14);
            x = nx;
            y = ny;
        end
        if (flags_r[1]) y = -y;
        amp = cordic_magnitude(x, y, raw);
        prv = sx32(last_phase);
        d = 0;
        if (seen_sample) begin
            dw = 16'(raw - prv);
            d = longint'(signed'(dw));
            unwr = prv + d;
            if (unwr > 64'sd2147483647) unwr = 64'sd2147483647;
            if (unwr < -64'sd2147483648) unwr = -64'sd2147483648;
        end
        else begin
            unwr = raw;
        end
        case (mode_r)
            MODE_IQ: begin
                r.first = apply_gain(x, gains_r[31:16], 17);
                r.second = apply_gain(y, gains_r[31:16], 17);
            end
            MODE_AMP_PHASE: begin
                r.first = apply_gain(amp, gains_r[31:16], 17);
                r.second = apply_gain(unwr, gains_r[15:0], 8);
            end
            MODE_AMP_FREQ: begin
                r.first = apply_gain(amp, gains_r[31:16], 17);
                r.second = apply_gain(d, gains_r[15:0], 8);
            end
            default: r = '0;
        endcase
        last_phase = unwr[31:0];
        seen_sample = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what,
                 signed'(got), signed'(want), $realtime);
        errors++;
    endtask

    // Output checker; also drives the receiver stall pattern.
    always @(posedge clk) begin
        out_pair_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_pairs.size() == 0) begin
                $display("unexpected output item at %0t", $realtime);
                errors++;
            end
            else begin
                e = pending_pairs.pop_front();
                if (first_out !== e.first) report_mismatch("first_out", first_out, e.first);
                if (second_out !== e.second)
                    report_mismatch("second_out", second_out, e.second);
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // The item stays offered after acceptance ends; the next call or drain
    // takes valid down.
    task automatic send_sample(logic [15:0] isamp, logic [15:0] qsamp);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        i_sample <= isamp;
        q_sample <= qsamp;
        pending_pairs.push_back(demodulate(isamp, qsamp));
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_OUTPUT_MODE:      mode_r = val[1:0];
            REG_NCO_STEP:         step_r = val[31:0];
            REG_START_PHASE:      start_r = val[15:0];
            REG_ORIGIN_OFFSETS:   offsets_r = val[31:0];
            REG_IQ_ROTATION:      rot_r = val[15:0];
            REG_IMBALANCE_MATRIX: matrix_r = val;
            REG_OUTPUT_GAINS:     gains_r = val[31:0];
            REG_OPTION_FLAGS:     flags_r = val[1:0];
            default: ;
        endcase
    endtask

    // Plain I/Q pass with default registers: field extremes and the zero vector.
    task automatic test_directed_extremes();
        logic [15:0] v[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
        foreach (v[a]) foreach (v[b]) send_sample(v[a], v[b]);
        drain();
    endtask

    // Phase unwrap: a spinning carrier and the negative real axis.
    task automatic test_unwrap();
        write_reg(REG_OUTPUT_MODE, MODE_AMP_PHASE);
        write_reg(REG_NCO_STEP, 32'h7000_0000);
        write_reg(REG_OUTPUT_GAINS, 32'h0100_0100);
        send_sample(16'h8000, 16'h0000);
        for (int n = 0; n < 60; n++) send_sample(16'h4000, 16'h0000);
        drain();
        // A step of exactly a half turn per sample in frequency mode.
        write_reg(REG_OUTPUT_MODE, MODE_AMP_FREQ);
        write_reg(REG_NCO_STEP, 32'h8000_0000);
        for (int n = 0; n < 10; n++) send_sample(16'h3000, 16'h0000);
        drain();
        // The unused mode still advances the state.
        write_reg(REG_OUTPUT_MODE, 2'd3);
        for (int n = 0; n < 4; n++) send_sample(16'h1234, 16'hedcb);
        drain();
    endtask

    task automatic random_block(int count, int wellformed);
        logic [15:0] ii, qq;
        for (int n = 0; n < count; n++) begin
            if (wellformed && ($urandom_range(3) != 0)) begin
                ii = 16'($urandom_range(16000)) - 16'd8000;
                qq = 16'($urandom_range(16000)) - 16'd8000;
            end
            else begin
                ii = 16'($urandom);
                qq = 16'($urandom);
            end
            send_sample(ii, qq);
        end
    endtask

    // Random registers, including extremes, under each idling profile.
    task automatic test_random_settings(int phases);
        logic [31:0] gpick[4] = '{32'h7fff_7fff, 32'h8000_8000, 32'h0100_0100, 32'h0040_2000};
        for (int p = 0; p < phases; p++) begin
            write_reg(REG_OUTPUT_MODE, $urandom_range(3));
            write_reg(REG_NCO_STEP, (p % 4 == 0) ? 32'hffff_ffff : $urandom);
            write_reg(REG_START_PHASE, (p % 5 == 0) ? 16'hffff : 16'($urandom));
            write_reg(REG_ORIGIN_OFFSETS, (p % 3 == 0) ? 32'h7fff_8000 : $urandom & 32'h0fff_0fff);
            write_reg(REG_IQ_ROTATION, $urandom);
            write_reg(REG_IMBALANCE_MATRIX, (p % 4 == 1) ? 64'h7fff_8000_8000_7fff
                      : {$urandom, $urandom} & 64'h5fff_1fff_1fff_5fff);
            write_reg(REG_OUTPUT_GAINS, (p % 2) ? gpick[$urandom_range(3)] : $urandom);
            write_reg(REG_OPTION_FLAGS, $urandom_range(3));
            random_block(110, 1);
            drain();
        end
    endtask

    // Receiver holds off while items keep coming, so the input must stall.
    task automatic test_backpressure();
        write_reg(REG_OUTPUT_MODE, MODE_AMP_PHASE);
        hold_cycles = 300;
        random_block(40, 1);
        drain();
    endtask

    initial begin
        nco_acc = '0;
        last_phase = '0;
        seen_sample = 1'b0;
        mode_r = '0;
        step_r = '0;
        start_r = '0;
        offsets_r = '0;
        rot_r = '0;
        matrix_r = 64'h4000_0000_0000_4000;
        gains_r = 32'h0100_0100;
        flags_r = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_unwrap();
        send_gap_pct = 16;
        recv_stall_pct = 88;
        test_random_settings(5);
        send_gap_pct = 88;
        recv_stall_pct = 16;
        test_random_settings(5);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random_settings(6);
        test_backpressure();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
